// ===== hdl/paf_pkg.sv =====
`timescale 1ns / 1ps

package paf_pkg;

    localparam int NUM_FRAMES_DEF = 1024;
    localparam int REF_BITS_DEF   = 16;

    localparam logic [2:0] OP_ALLOC_ONE = 3'd0;
    localparam logic [2:0] OP_FREE_ONE  = 3'd1;
    localparam logic [2:0] OP_ALLOC_RUN = 3'd2;
    localparam logic [2:0] OP_FREE_RUN  = 3'd3;
    localparam logic [2:0] OP_ADD       = 3'd4;
    localparam logic [2:0] OP_RESERVE   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] A_HEAD = 3'd0;
    localparam logic [2:0] A_FI   = 3'd1;
    localparam logic [2:0] A_POS  = 3'd2;
    localparam logic [2:0] A_POSI = 3'd3;
    localparam logic [2:0] A_FII  = 3'd4;

    typedef struct packed {
        logic       clr;
        logic       ld_item;
        logic       rd;
        logic [2:0] asel;
        logic       w1take;
        logic       w1drop;
        logic       w1push;
        logic       w2;
        logic       pos_head;
        logic       pos_next;
        logic       i_clr;
        logic       i_inc;
        logic       out_ld;
        logic [1:0] st;
        logic       zr;
    } paf_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       head_null;
        logic       fi_valid;
        logic       tgt_bad;
        logic       rc_zero;
        logic       rc_max;
        logic       i_done;
        logic       pos_null;
        logic       steps_done;
        logic       out_free;
        logic [2:0] op;
    } paf_sts_t;

endpackage

// ===== hdl/paf_datapath.sv =====
`timescale 1ns / 1ps

module paf_datapath #(
    parameter int NUM_FRAMES = 1024,
    parameter int REF_BITS   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  paf_pkg::paf_cmd_t  cmd,
    output paf_pkg::paf_sts_t  sts,
    input  logic [2:0]         in_op,
    input  logic [9:0]         in_frame_index,
    input  logic [10:0]        in_run_length,
    input  logic               cfg_wr_en,
    input  logic [10:0]        cfg_wr_data,
    input  logic               m_tready,
    output logic               m_valid,
    output logic [1:0]         m_status,
    output logic [9:0]         m_result_frame,
    output logic [15:0]        m_ref_after
);
    import paf_pkg::*;

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int LW = $clog2(NUM_FRAMES + 1);
    localparam int FW = ((LW > 11) ? LW : 11) + 1;
    localparam int RW = REF_BITS;
    localparam logic [LW-1:0] NULL_L = LW'(NUM_FRAMES);

    logic [RW-1:0] ref_mem [NUM_FRAMES];
    logic [LW-1:0] nl_mem  [NUM_FRAMES];
    logic [LW-1:0] pl_mem  [NUM_FRAMES];

    logic [2:0]    op_reg;
    logic [9:0]    fi_reg;
    logic [10:0]   len_reg;
    logic [10:0]   fiu_reg;
    logic [LW-1:0] head_reg;
    logic [LW-1:0] pos_reg;
    logic [10:0]   i_reg;
    logic [LW-1:0] steps_reg;
    logic [FW-1:0] tgt_reg;
    logic          kind_take_reg;
    logic          onl_reg;
    logic          push_reg;
    logic [IW-1:0] clr_cnt_reg;
    logic          m_valid_reg;
    logic [1:0]    st_out_reg;
    logic [9:0]    res_out_reg;
    logic [15:0]   refa_out_reg;

    logic [RW-1:0] rc_q;
    logic [LW-1:0] nx_q;
    logic [LW-1:0] pv_q;

    logic [FW-1:0] ra;
    logic [IW-1:0] tgt_idx;
    logic          onlist;
    logic          head_is_tgt;
    logic [RW-1:0] rc_inc;
    logic [RW-1:0] rc_dec;

    logic          ref_we;
    logic [IW-1:0] ref_wa;
    logic [RW-1:0] ref_wd;
    logic          nl_we;
    logic [IW-1:0] nl_wa;
    logic [LW-1:0] nl_wd;
    logic          pl_we;
    logic [IW-1:0] pl_wa;
    logic [LW-1:0] pl_wd;

    always_comb begin
        unique case (cmd.asel)
            A_HEAD:  ra = FW'(head_reg);
            A_FI:    ra = FW'(fi_reg);
            A_POS:   ra = FW'(pos_reg);
            A_POSI:  ra = FW'(pos_reg) + FW'(i_reg);
            A_FII:   ra = FW'(fi_reg) + FW'(i_reg);
            default: ra = FW'(fi_reg);
        endcase
    end

    assign tgt_idx     = tgt_reg[IW-1:0];
    assign head_is_tgt = (FW'(head_reg) == tgt_reg);
    assign onlist      = head_is_tgt || (pv_q != NULL_L);
    assign rc_inc      = rc_q + RW'(1);
    assign rc_dec      = rc_q - RW'(1);

    always_comb begin
        ref_we = 1'b0;
        ref_wa = tgt_idx;
        ref_wd = rc_inc;
        nl_we  = 1'b0;
        nl_wa  = tgt_idx;
        nl_wd  = NULL_L;
        pl_we  = 1'b0;
        pl_wa  = tgt_idx;
        pl_wd  = NULL_L;
        if (cmd.clr) begin
            ref_we = 1'b1;
            ref_wa = clr_cnt_reg;
            ref_wd = '0;
            nl_we  = 1'b1;
            nl_wa  = clr_cnt_reg;
            pl_we  = 1'b1;
            pl_wa  = clr_cnt_reg;
        end else if (cmd.w1take) begin
            ref_we = 1'b1;
            if (onlist) begin
                if (!head_is_tgt && (pv_q != NULL_L)) begin
                    nl_we = 1'b1;
                    nl_wa = pv_q[IW-1:0];
                    nl_wd = nx_q;
                end
                if (nx_q != NULL_L) begin
                    pl_we = 1'b1;
                    pl_wa = nx_q[IW-1:0];
                    pl_wd = pv_q;
                end
            end
        end else if (cmd.w1drop) begin
            ref_we = 1'b1;
            ref_wd = rc_dec;
            if ((rc_dec == '0) && !onlist) begin
                nl_we = 1'b1;
                nl_wd = head_reg;
                pl_we = 1'b1;
            end
        end else if (cmd.w1push) begin
            if (!onlist) begin
                nl_we = 1'b1;
                nl_wd = head_reg;
                pl_we = 1'b1;
            end
        end else if (cmd.w2) begin
            if (kind_take_reg) begin
                if (onl_reg) begin
                    nl_we = 1'b1;
                    pl_we = 1'b1;
                end
            end else if (push_reg && (head_reg != NULL_L)) begin
                pl_we = 1'b1;
                pl_wa = head_reg[IW-1:0];
                pl_wd = LW'(tgt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (nl_we) begin
            nl_mem[nl_wa] <= nl_wd;
        end
        if (pl_we) begin
            pl_mem[pl_wa] <= pl_wd;
        end
        if (cmd.rd) begin
            rc_q    <= ref_mem[ra[IW-1:0]];
            nx_q    <= nl_mem[ra[IW-1:0]];
            pv_q    <= pl_mem[ra[IW-1:0]];
            tgt_reg <= ra;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            op_reg  <= in_op;
            fi_reg  <= in_frame_index;
            len_reg <= in_run_length;
        end
        if (cmd.pos_head) begin
            pos_reg   <= head_reg;
            steps_reg <= '0;
        end else if (cmd.pos_next) begin
            pos_reg   <= nx_q;
            steps_reg <= steps_reg + LW'(1);
        end
        if (cmd.i_clr) begin
            i_reg <= '0;
        end else if (cmd.i_inc) begin
            i_reg <= i_reg + 11'd1;
        end
        if (cmd.w1take || cmd.w1drop || cmd.w1push) begin
            kind_take_reg <= cmd.w1take;
            onl_reg       <= onlist;
            push_reg      <= cmd.w1drop ? ((rc_dec == '0) && !onlist) : !onlist;
        end
        if (cmd.out_ld) begin
            st_out_reg   <= cmd.st;
            res_out_reg  <= ((cmd.st == ST_OK) &&
                             ((op_reg == OP_ALLOC_ONE) || (op_reg == OP_ALLOC_RUN)))
                            ? 10'(pos_reg) : 10'd0;
            refa_out_reg <= cmd.zr ? 16'd0 : 16'(rc_q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= NULL_L;
            fiu_reg     <= 11'd1024;
            m_valid_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                fiu_reg <= cfg_wr_data;
            end
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (cmd.w1take && onlist && head_is_tgt) begin
                head_reg <= nx_q;
            end else if (cmd.w2 && !kind_take_reg && push_reg) begin
                head_reg <= LW'(tgt_reg);
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_done   = (clr_cnt_reg == IW'(NUM_FRAMES - 1));
    assign sts.head_null  = (head_reg == NULL_L);
    assign sts.fi_valid   = (FW'(fi_reg) < FW'(fiu_reg)) && (FW'(fi_reg) < FW'(NUM_FRAMES));
    assign sts.tgt_bad    = (tgt_reg >= FW'(fiu_reg)) || (tgt_reg >= FW'(NUM_FRAMES));
    assign sts.rc_zero    = (rc_q == '0);
    assign sts.rc_max     = (rc_q == '1);
    assign sts.i_done     = (i_reg == len_reg);
    assign sts.pos_null   = (pos_reg == NULL_L);
    assign sts.steps_done = (steps_reg == LW'(NUM_FRAMES));
    assign sts.out_free   = !m_valid_reg || m_tready;
    assign sts.op         = op_reg;

    assign m_valid        = m_valid_reg;
    assign m_status       = st_out_reg;
    assign m_result_frame = res_out_reg;
    assign m_ref_after    = refa_out_reg;

endmodule

// ===== hdl/paf_controller.sv =====
`timescale 1ns / 1ps

module paf_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               in_ready,
    input  paf_pkg::paf_sts_t  sts,
    output paf_pkg::paf_cmd_t  cmd
);
    import paf_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_EV    = 5'd3;
    localparam logic [4:0] S_W2    = 5'd4;
    localparam logic [4:0] S_FRD   = 5'd5;
    localparam logic [4:0] S_FIN   = 5'd6;
    localparam logic [4:0] S_C_RD  = 5'd7;
    localparam logic [4:0] S_C_EV  = 5'd8;
    localparam logic [4:0] S_N_EV  = 5'd9;
    localparam logic [4:0] S_N_CK  = 5'd10;
    localparam logic [4:0] S_A_TK  = 5'd11;
    localparam logic [4:0] S_A_EV  = 5'd12;
    localparam logic [4:0] S_F_CK  = 5'd13;
    localparam logic [4:0] S_F_EV  = 5'd14;
    localparam logic [4:0] S_F_DR  = 5'd15;
    localparam logic [4:0] S_F_DEV = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       zr_reg, zr_next;

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        st_next    = st_reg;
        zr_next    = zr_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld_item = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (sts.op)
                    OP_ALLOC_ONE: begin
                        if (sts.head_null) begin
                            st_next    = ST_NONE;
                            zr_next    = 1'b1;
                            state_next = S_FIN;
                        end else begin
                            cmd.pos_head = 1'b1;
                            cmd.rd       = 1'b1;
                            cmd.asel     = A_HEAD;
                            state_next   = S_EV;
                        end
                    end
                    OP_FREE_ONE, OP_ADD, OP_RESERVE: begin
                        if (!sts.fi_valid) begin
                            st_next    = ST_ERROR;
                            zr_next    = 1'b1;
                            state_next = S_FIN;
                        end else begin
                            cmd.rd     = 1'b1;
                            cmd.asel   = A_FI;
                            state_next = S_EV;
                        end
                    end
                    OP_ALLOC_RUN: begin
                        if (sts.head_null) begin
                            st_next    = ST_NONE;
                            zr_next    = 1'b1;
                            state_next = S_FIN;
                        end else begin
                            cmd.pos_head = 1'b1;
                            cmd.i_clr    = 1'b1;
                            state_next   = S_C_RD;
                        end
                    end
                    OP_FREE_RUN: begin
                        if (!sts.fi_valid) begin
                            st_next    = ST_ERROR;
                            zr_next    = 1'b1;
                            state_next = S_FIN;
                        end else begin
                            cmd.i_clr  = 1'b1;
                            state_next = S_F_CK;
                        end
                    end
                    default: begin
                        st_next    = ST_ERROR;
                        zr_next    = 1'b1;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_EV: begin
                st_next = ST_OK;
                zr_next = 1'b0;
                priority case (sts.op)
                    OP_FREE_ONE: begin
                        if (sts.rc_zero) begin
                            st_next    = ST_ERROR;
                            zr_next    = 1'b1;
                            state_next = S_FIN;
                        end else begin
                            cmd.w1drop = 1'b1;
                            state_next = S_W2;
                        end
                    end
                    OP_ADD: begin
                        if (!sts.rc_zero) begin
                            st_next    = ST_ERROR;
                            state_next = S_FIN;
                        end else begin
                            cmd.w1push = 1'b1;
                            state_next = S_W2;
                        end
                    end
                    OP_RESERVE: begin
                        if (sts.rc_max) begin
                            st_next    = ST_ERROR;
                            state_next = S_FIN;
                        end else begin
                            cmd.w1take = 1'b1;
                            state_next = S_W2;
                        end
                    end
                    default: begin
                        cmd.w1take = 1'b1;
                        state_next = S_W2;
                    end
                endcase
            end
            S_W2: begin
                cmd.w2 = 1'b1;
                priority case (sts.op)
                    OP_ALLOC_RUN: begin
                        cmd.i_inc  = 1'b1;
                        state_next = S_A_TK;
                    end
                    OP_FREE_RUN: begin
                        cmd.i_inc  = 1'b1;
                        state_next = S_F_DR;
                    end
                    OP_ADD: begin
                        st_next    = ST_OK;
                        zr_next    = 1'b1;
                        state_next = S_FIN;
                    end
                    default: begin
                        st_next    = ST_OK;
                        zr_next    = 1'b0;
                        state_next = S_FRD;
                    end
                endcase
            end
            S_FRD: begin
                cmd.rd     = 1'b1;
                cmd.asel   = ((sts.op == OP_ALLOC_ONE) || (sts.op == OP_ALLOC_RUN))
                             ? A_POS : A_FI;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    cmd.st     = st_reg;
                    cmd.zr     = zr_reg;
                    state_next = S_IDLE;
                end
            end
            S_C_RD: begin
                if (sts.i_done) begin
                    cmd.i_clr  = 1'b1;
                    state_next = S_A_TK;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.asel   = A_POSI;
                    state_next = S_C_EV;
                end
            end
            S_C_EV: begin
                if (sts.tgt_bad || !sts.rc_zero) begin
                    cmd.rd     = 1'b1;
                    cmd.asel   = A_POS;
                    state_next = S_N_EV;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_C_RD;
                end
            end
            S_N_EV: begin
                cmd.pos_next = 1'b1;
                cmd.i_clr    = 1'b1;
                state_next   = S_N_CK;
            end
            S_N_CK: begin
                if (sts.pos_null || sts.steps_done) begin
                    st_next    = ST_NONE;
                    zr_next    = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_C_RD;
                end
            end
            S_A_TK: begin
                if (sts.i_done) begin
                    st_next    = ST_OK;
                    zr_next    = 1'b0;
                    state_next = S_FRD;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.asel   = A_POSI;
                    state_next = S_A_EV;
                end
            end
            S_A_EV: begin
                cmd.w1take = 1'b1;
                state_next = S_W2;
            end
            S_F_CK: begin
                if (sts.i_done) begin
                    cmd.i_clr  = 1'b1;
                    state_next = S_F_DR;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.asel   = A_FII;
                    state_next = S_F_EV;
                end
            end
            S_F_EV: begin
                if (sts.tgt_bad || sts.rc_zero) begin
                    st_next    = ST_ERROR;
                    zr_next    = 1'b0;
                    state_next = S_FRD;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_F_CK;
                end
            end
            S_F_DR: begin
                if (sts.i_done) begin
                    st_next    = ST_OK;
                    zr_next    = 1'b0;
                    state_next = S_FRD;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.asel   = A_FII;
                    state_next = S_F_DEV;
                end
            end
            S_F_DEV: begin
                cmd.w1drop = 1'b1;
                state_next = S_W2;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            st_reg    <= ST_OK;
            zr_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            zr_reg    <= zr_next;
        end
    end

endmodule

// ===== hdl/page_frame_allocator_top.sv =====
`timescale 1ns / 1ps
// one word at a time: the next word is taken only once the last one's result is loaded at the output
// run ops check each frame of the run first, then reference or free each one in turn;
// an alloc run skips on to the next free-list entry when a candidate run does not fit
// a result waiting at the output does not block the next accept
// after reset a clearing pass over all NUM_FRAMES entries runs before the first word is taken

module page_frame_allocator_top #(
    parameter int NUM_FRAMES = paf_pkg::NUM_FRAMES_DEF,
    parameter int REF_BITS   = paf_pkg::REF_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // frame_index, run_length
    input  logic [2:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_frame, ref_after
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);
    import paf_pkg::*;

    paf_cmd_t    cmd;
    paf_sts_t    sts;
    logic [9:0]  res_frame;
    logic [15:0] ref_after;

    paf_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    paf_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .REF_BITS   (REF_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_op          (s_tuser),
        .in_frame_index (s_tdata[9:0]),
        .in_run_length  (s_tdata[20:10]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_tready       (m_tready),
        .m_valid        (m_tvalid),
        .m_status       (m_tuser),
        .m_result_frame (res_frame),
        .m_ref_after    (ref_after)
    );

    assign m_tdata = {6'd0, ref_after, res_frame};

endmodule

// ===== tb/page_frame_allocator_top_test.sv =====
`timescale 1ns / 1ps

module page_frame_allocator_top_test;
    import paf_pkg::*;

    localparam int NFRAMES = 1024;
    localparam int NULL_LINK = 1024;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [2:0] OP_BAD_6 = 3'd6;
    localparam logic [2:0] OP_BAD_7 = 3'd7;
    localparam int IDLE_LIMIT = 8000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  frame;
        logic [15:0] refs;
    } outcome_t;

    typedef struct {
        logic [2:0]  op;
        logic [9:0]  fi;
        logic [10:0] len;
        bit          typed;
        outcome_t    want;
    } request_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;

    page_frame_allocator_top u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    logic [15:0] counts[NFRAMES];
    int          next_of[NFRAMES];
    int          prev_of[NFRAMES];
    int          list_head;
    int          frame_limit;

    outcome_t    pending[$];
    request_t    directed[$];
    bit          cur_typed;
    outcome_t    cur_want;
    int          errors;
    int          idle_cycles;
    bit          fast_mode;
    bit          hold_req;
    bit          gaps_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit listed(int f);
        return list_head == f || prev_of[f] != NULL_LINK;
    endfunction

    function automatic void unlink(int f);
        int nx;
        int pv;
        nx = next_of[f];
        pv = prev_of[f];
        if (list_head == f) begin
            list_head = nx;
        end else if (pv < NFRAMES) begin
            next_of[pv] = nx;
        end
        if (nx < NFRAMES) begin
            prev_of[nx] = pv;
        end
        next_of[f] = NULL_LINK;
        prev_of[f] = NULL_LINK;
    endfunction

    function automatic void push_free(int f);
        next_of[f] = list_head;
        prev_of[f] = NULL_LINK;
        if (list_head < NFRAMES) begin
            prev_of[list_head] = f;
        end
        list_head = f;
    endfunction

    function automatic void grab(int f);
        if (listed(f)) begin
            unlink(f);
        end
        counts[f] = counts[f] + 16'd1;
    endfunction

    function automatic void release_ref(int f);
        counts[f] = counts[f] - 16'd1;
        if (counts[f] == 0 && !listed(f)) begin
            push_free(f);
        end
    endfunction

    function automatic outcome_t allocate(logic [2:0] op, int fi, int len);
        outcome_t o;
        bit ok_idx;
        bit found;
        bit fits;
        int pos;
        int steps;
        o = '0;
        ok_idx = fi < frame_limit;
        case (op)
            OP_ALLOC_ONE: begin
                if (list_head >= NFRAMES) begin
                    o.status = ST_NONE;
                end else begin
                    o.frame = list_head[9:0];
                    grab(list_head);
                    o.refs = counts[o.frame];
                end
            end
            OP_FREE_ONE: begin
                if (!ok_idx || counts[fi] == 0) begin
                    o.status = ST_ERROR;
                end else begin
                    release_ref(fi);
                    o.refs = counts[fi];
                end
            end
            OP_ALLOC_RUN: begin
                pos = list_head;
                steps = 0;
                found = 0;
                while (!found && pos < NFRAMES && steps < NFRAMES) begin
                    fits = 1;
                    for (int i = 0; i < len && fits; i++) begin
                        if (pos + i >= frame_limit || counts[pos + i] != 0) begin
                            fits = 0;
                        end
                    end
                    if (fits) begin
                        found = 1;
                    end else begin
                        pos = next_of[pos];
                        steps++;
                    end
                end
                if (!found) begin
                    o.status = ST_NONE;
                end else begin
                    for (int i = 0; i < len; i++) begin
                        grab(pos + i);
                    end
                    o.frame = pos[9:0];
                    o.refs = counts[pos];
                end
            end
            OP_FREE_RUN: begin
                if (!ok_idx) begin
                    o.status = ST_ERROR;
                end else begin
                    fits = 1;
                    for (int i = 0; i < len && fits; i++) begin
                        if (fi + i >= frame_limit || counts[fi + i] == 0) begin
                            fits = 0;
                        end
                    end
                    if (!fits) begin
                        o.status = ST_ERROR;
                    end else begin
                        for (int i = 0; i < len; i++) begin
                            release_ref(fi + i);
                        end
                    end
                    o.refs = counts[fi];
                end
            end
            OP_ADD: begin
                if (!ok_idx) begin
                    o.status = ST_ERROR;
                end else if (counts[fi] != 0) begin
                    o.status = ST_ERROR;
                    o.refs = counts[fi];
                end else if (!listed(fi)) begin
                    push_free(fi);
                end
            end
            OP_RESERVE: begin
                if (!ok_idx) begin
                    o.status = ST_ERROR;
                end else if (counts[fi] == COUNT_MAX) begin
                    o.status = ST_ERROR;
                    o.refs = counts[fi];
                end else begin
                    grab(fi);
                    o.refs = counts[fi];
                end
            end
            default: begin
                o.status = ST_ERROR;
            end
        endcase
        return o;
    endfunction

    // prediction and checking
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t exp_o;
        outcome_t pred;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred = allocate(s_tuser, s_tdata[9:0], s_tdata[20:10]);
                pending.push_back(cur_typed ? cur_want : pred);
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.frame = m_tdata[9:0];
                got.refs = m_tdata[25:10];
                if (pending.size() == 0) begin
                    $display("%0t: unexpected word status=%0d frame=%0d refs=%0d",
                             $time, got.status, got.frame, got.refs);
                    errors++;
                end else begin
                    exp_o = pending.pop_front();
                    if (got.status !== exp_o.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_o.status, got.status);
                        errors++;
                    end
                    if (got.frame !== exp_o.frame) begin
                        $display("%0t: result_frame expected %0d actual %0d",
                                 $time, exp_o.frame, got.frame);
                        errors++;
                    end
                    if (got.refs !== exp_o.refs) begin
                        $display("%0t: ref_after expected %0d actual %0d",
                                 $time, exp_o.refs, got.refs);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 0;
            end
            if (fast_mode || !gaps_on) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= (pick_gap() == 0);
            end
        end
    end

    task automatic send(logic [2:0] op, logic [9:0] fi, logic [10:0] len,
                        bit typed, outcome_t want);
        int gap;
        gap = (fast_mode || !gaps_on) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b0, len, fi};
        cur_typed <= typed;
        cur_want <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic settle_and_write(int value);
        s_tvalid <= 1'b0;
        wait (pending.size() == 0);
        repeat (40) @(negedge aclk);
        frame_limit = value < NFRAMES ? value : NFRAMES;
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[10:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void row(logic [2:0] op, int fi, int len, bit typed,
                                logic [1:0] st, int fr, int rf);
        request_t r;
        r.op = op;
        r.fi = fi[9:0];
        r.len = len[10:0];
        r.typed = typed;
        r.want.status = st;
        r.want.frame = fr[9:0];
        r.want.refs = rf[15:0];
        directed.push_back(r);
    endfunction

    task automatic random_phase(int n);
        logic [2:0]  op;
        logic [9:0]  fi;
        logic [10:0] len;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 20) op = OP_ALLOC_ONE;
            else if (r < 40) op = OP_FREE_ONE;
            else if (r < 53) op = OP_ALLOC_RUN;
            else if (r < 63) op = OP_FREE_RUN;
            else if (r < 83) op = OP_ADD;
            else if (r < 95) op = OP_RESERVE;
            else op = $urandom_range(0, 1) ? OP_BAD_6 : OP_BAD_7;
            if ($urandom_range(0, 9) == 0) fi = 10'($urandom_range(0, 1023));
            else fi = 10'($urandom_range(0, frame_limit - 1));
            r = $urandom_range(0, 99);
            if (r < 2) len = 11'($urandom_range(0, 1024));
            else if (r == 2) len = 11'd1024;
            else len = 11'($urandom_range(0, 6));
            if (k == n / 3 && !hold_req) hold_req = 1;
            send(op, fi, len, 0, '0);
        end
    endtask

    initial begin
        int phase_limits[5];
        errors = 0;
        idle_cycles = 0;
        fast_mode = 0;
        hold_req = 0;
        gaps_on = 1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        cur_typed = 0;
        cur_want = '0;
        frame_limit = NFRAMES;
        list_head = NULL_LINK;
        for (int i = 0; i < NFRAMES; i++) begin
            counts[i] = '0;
            next_of[i] = NULL_LINK;
            prev_of[i] = NULL_LINK;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty list, underflow, add/reserve/free, runs, undefined ops
        row(OP_ALLOC_ONE, 0, 0, 1, ST_NONE, 0, 0);
        row(OP_ALLOC_RUN, 0, 1, 1, ST_NONE, 0, 0);
        row(OP_FREE_ONE, 5, 0, 1, ST_ERROR, 0, 0);
        row(OP_ADD, 1023, 0, 1, ST_OK, 0, 0);
        row(OP_ADD, 0, 0, 1, ST_OK, 0, 0);
        row(OP_ADD, 0, 0, 1, ST_OK, 0, 0);
        row(OP_RESERVE, 1023, 0, 1, ST_OK, 0, 1);
        row(OP_ADD, 1023, 0, 1, ST_ERROR, 0, 1);
        row(OP_FREE_ONE, 1023, 0, 1, ST_OK, 0, 0);
        row(OP_ALLOC_ONE, 0, 0, 1, ST_OK, 1023, 1);
        row(OP_ALLOC_RUN, 0, 0, 0, ST_OK, 0, 0);
        row(OP_ALLOC_RUN, 0, 4, 0, ST_OK, 0, 0);
        row(OP_FREE_RUN, 0, 4, 0, ST_OK, 0, 0);
        row(OP_FREE_RUN, 0, 0, 0, ST_OK, 0, 0);
        row(OP_FREE_RUN, 1020, 4, 1, ST_ERROR, 0, 0);
        row(OP_ALLOC_RUN, 0, 1024, 0, ST_OK, 0, 0);
        row(OP_FREE_RUN, 0, 1024, 0, ST_OK, 0, 0);
        row(OP_FREE_ONE, 1023, 0, 1, ST_OK, 0, 0);
        row(OP_ALLOC_RUN, 0, 1024, 0, ST_OK, 0, 0);
        row(OP_FREE_RUN, 0, 1024, 0, ST_OK, 0, 0);
        row(OP_BAD_6, 1023, 2047, 1, ST_ERROR, 0, 0);
        row(OP_BAD_7, 0, 0, 1, ST_ERROR, 0, 0);
        foreach (directed[k]) begin
            send(directed[k].op, directed[k].fi, directed[k].len,
                 directed[k].typed, directed[k].want);
        end

        settle_and_write(1);
        send(OP_FREE_ONE, 10'd5, 11'd0, 1, '{ST_ERROR, 10'd0, 16'd0});

        phase_limits = '{1, 16, 64, 1024, 300};
        foreach (phase_limits[p]) begin
            if (p > 0) settle_and_write(phase_limits[p]);
            gaps_on = (p != 2);
            random_phase(180);
        end
        s_tvalid <= 1'b0;
        wait (pending.size() == 0);
        repeat (100) @(negedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
